[rtl/cgw_pkg.sv]
// ----------------------------------------------------------------------------
// cgw_pkg
// Shared types, constants and codes of the circle against grid wall collision
// block: sizes, field widths, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package cgw_pkg;

	localparam int MAX_WIDTH        = 256;
	localparam int MAX_HEIGHT       = 256;
	localparam int MAX_RADIUS_CELLS = 8;

	localparam int MAP_CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int MAP_AW    = $clog2(MAP_CELLS);
	localparam int CELL_W    = $clog2(MAX_WIDTH);
	localparam int DIM_W     = 9;

	localparam int R_W       = 12;
	localparam int C_W       = 17;
	localparam int DX_W      = 14;
	localparam int D2_W      = 24;
	localparam int SQ_IN_W   = D2_W + 28;
	localparam int ROOT_W    = SQ_IN_W / 2;
	localparam int SQ_REM_W  = ROOT_W + 1;
	localparam int NUM_W     = (DX_W - 1) + 28 + 1;
	localparam int Q_W       = 17;
	localparam int N_W       = 16;

	localparam logic [R_W-1:0] R_MAX    = R_W'(MAX_RADIUS_CELLS * 256);
	localparam logic [N_W-1:0] NORM_ONE = N_W'(16384);

	// Item kinds carried on tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN,
		ST_SQRT,
		ST_DIVX,
		ST_DIVY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [MAP_AW-1:0]   cell_index;
		logic                cell_is_wall;
		logic signed [C_W-1:0] center_x;
		logic signed [C_W-1:0] center_y;
		logic [R_W-1:0]      circle_radius;
	} item_t;

	typedef struct packed {
		logic            hit;
		logic [R_W-1:0]  penetration;
		logic [N_W-1:0]  normal_x;
		logic [N_W-1:0]  normal_y;
	} result_t;

	typedef struct packed {
		logic clr;
		logic wr;
		logic load;
		logic start;
		logic scan;
		logic sq_init;
		logic sq_step;
		logic dv_init;
		logic dv_sel;
		logic dv_step;
		logic ld_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic empty;
		logic scan_last;
		logic pipe_busy;
		logic sq_last;
		logic dv_last;
		logic out_free;
	} status_t;

endpackage

[rtl/cgw_ram.sv]
// ----------------------------------------------------------------------------
// cgw_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module cgw_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/cgw_ctrl.sv]
// ----------------------------------------------------------------------------
// cgw_ctrl
// Sequencer: clearing pass, item intake, cell scan, drain, square root,
// two divides and result hand-off.
// ----------------------------------------------------------------------------
module cgw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_op,
	input  cgw_pkg::status_t sts,
	output logic             in_ready,
	output cgw_pkg::cmd_t    cmd
);

	cgw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cgw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cgw_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = cgw_pkg::ST_IDLE;
			end
			cgw_pkg::ST_IDLE: begin
				if (in_valid && in_op == cgw_pkg::OP_QUERY) state_d = cgw_pkg::ST_SETUP;
			end
			cgw_pkg::ST_SETUP: begin
				state_d = sts.empty ? cgw_pkg::ST_DRAIN : cgw_pkg::ST_SCAN;
			end
			cgw_pkg::ST_SCAN: begin
				if (sts.scan_last) state_d = cgw_pkg::ST_DRAIN;
			end
			cgw_pkg::ST_DRAIN: begin
				if (!sts.pipe_busy) state_d = cgw_pkg::ST_SQRT;
			end
			cgw_pkg::ST_SQRT: begin
				if (sts.sq_last) state_d = cgw_pkg::ST_DIVX;
			end
			cgw_pkg::ST_DIVX: begin
				if (sts.dv_last) state_d = cgw_pkg::ST_DIVY;
			end
			cgw_pkg::ST_DIVY: begin
				if (sts.dv_last) state_d = cgw_pkg::ST_DONE;
			end
			cgw_pkg::ST_DONE: begin
				if (sts.out_free) state_d = cgw_pkg::ST_IDLE;
			end
			default: state_d = cgw_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			cgw_pkg::ST_CLEAR: cmd.clr = 1'b1;
			cgw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.wr   = in_valid && in_op == cgw_pkg::OP_WRITE;
				cmd.load = in_valid && in_op == cgw_pkg::OP_QUERY;
			end
			cgw_pkg::ST_SETUP: cmd.start = 1'b1;
			cgw_pkg::ST_SCAN:  cmd.scan = 1'b1;
			cgw_pkg::ST_DRAIN: cmd.sq_init = !sts.pipe_busy;
			cgw_pkg::ST_SQRT: begin
				cmd.sq_step = 1'b1;
				cmd.dv_init = sts.sq_last;
			end
			cgw_pkg::ST_DIVX: begin
				cmd.dv_step = 1'b1;
				cmd.dv_init = sts.dv_last;
				cmd.dv_sel  = sts.dv_last;
			end
			cgw_pkg::ST_DIVY: begin
				cmd.dv_step = 1'b1;
				cmd.dv_sel  = 1'b1;
			end
			cgw_pkg::ST_DONE: cmd.ld_out = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/cgw_dp.sv]
// ----------------------------------------------------------------------------
// cgw_dp
// Datapath: wall map, bounding box, cell scan pipeline, best cell tracking,
// shared square root and divide units, result assembly.
// ----------------------------------------------------------------------------
module cgw_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cgw_pkg::cmd_t                 cmd,
	input  cgw_pkg::item_t                item,
	input  logic [cgw_pkg::DIM_W-1:0]     grid_width,
	input  logic [cgw_pkg::DIM_W-1:0]     grid_height,
	output cgw_pkg::status_t              sts,
	output cgw_pkg::result_t              res
);

	localparam int CW = cgw_pkg::CELL_W;
	localparam int AW = cgw_pkg::MAP_AW;

	// ---------------- wall map and clearing pass ----------------
	logic [AW-1:0] clr_q;
	logic [AW-1:0] scan_addr;
	logic          rd_wall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	cgw_ram #(.WIDTH(1), .DEPTH(cgw_pkg::MAP_CELLS)) u_map (
		.clk   (clk),
		.we    (cmd.clr | cmd.wr),
		.waddr (cmd.clr ? clr_q : item.cell_index),
		.wdata (cmd.clr ? 1'b0 : item.cell_is_wall),
		.raddr (scan_addr),
		.rdata (rd_wall)
	);

	// ---------------- query capture and bounding box ----------------
	logic [cgw_pkg::DIM_W-1:0] w_eff, h_eff, w_q;
	logic [cgw_pkg::R_W-1:0]   r_sat, r_q;
	logic signed [cgw_pkg::C_W-1:0] cx_q, cy_q;
	logic signed [19:0] lo_x, hi_x, lo_y, hi_y;
	logic signed [11:0] x0, x1, y0, y1, wm1, hm1;
	logic [CW-1:0] x0_q, x1_q, y0_q, y1_q;
	logic          empty_q;
	logic [cgw_pkg::D2_W-1:0] r2_q;

	assign w_eff = (grid_width  > cgw_pkg::DIM_W'(cgw_pkg::MAX_WIDTH))
		? cgw_pkg::DIM_W'(cgw_pkg::MAX_WIDTH) : grid_width;
	assign h_eff = (grid_height > cgw_pkg::DIM_W'(cgw_pkg::MAX_HEIGHT))
		? cgw_pkg::DIM_W'(cgw_pkg::MAX_HEIGHT) : grid_height;
	assign r_sat = (item.circle_radius > cgw_pkg::R_MAX) ? cgw_pkg::R_MAX : item.circle_radius;

	always_comb begin
		lo_x = {{3{item.center_x[16]}}, item.center_x} - {8'b0, r_sat};
		hi_x = {{3{item.center_x[16]}}, item.center_x} + {8'b0, r_sat} + 20'sd255;
		lo_y = {{3{item.center_y[16]}}, item.center_y} - {8'b0, r_sat};
		hi_y = {{3{item.center_y[16]}}, item.center_y} + {8'b0, r_sat} + 20'sd255;
		wm1  = $signed({3'b0, w_eff}) - 12'sd1;
		hm1  = $signed({3'b0, h_eff}) - 12'sd1;
		x0   = ($signed(lo_x[19:8]) < 12'sd0) ? 12'sd0 : $signed(lo_x[19:8]);
		y0   = ($signed(lo_y[19:8]) < 12'sd0) ? 12'sd0 : $signed(lo_y[19:8]);
		x1   = ($signed(hi_x[19:8]) > wm1) ? wm1 : $signed(hi_x[19:8]);
		y1   = ($signed(hi_y[19:8]) > hm1) ? hm1 : $signed(hi_y[19:8]);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= item.center_x;
			cy_q    <= item.center_y;
			r_q     <= r_sat;
			w_q     <= w_eff;
			x0_q    <= x0[CW-1:0];
			x1_q    <= x1[CW-1:0];
			y0_q    <= y0[CW-1:0];
			y1_q    <= y1[CW-1:0];
			empty_q <= (w_eff == '0) || (h_eff == '0) || (x0 > x1) || (y0 > y1);
		end
		if (cmd.start) begin
			r2_q <= cgw_pkg::D2_W'(r_q) * cgw_pkg::D2_W'(r_q);
		end
	end

	// ---------------- scan counters ----------------
	logic [CW-1:0] px_q, py_q;
	logic [AW-1:0] base_q;

	assign scan_addr = base_q + AW'(px_q);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q   <= x0_q;
			py_q   <= y0_q;
			base_q <= AW'(y0_q) * AW'(w_q);
		end else if (cmd.scan) begin
			if (px_q == x1_q) begin
				px_q   <= x0_q;
				py_q   <= py_q + 1'b1;
				base_q <= base_q + AW'(w_q);
			end else begin
				px_q <= px_q + 1'b1;
			end
		end
	end

	// ---------------- cell pipeline ----------------
	logic          v_s1, v_s2, v_s3;
	logic [CW-1:0] px_s1, py_s1;
	logic signed [cgw_pkg::DX_W-1:0] dx_s2, dy_s2, dx_s3, dy_s3;
	logic [cgw_pkg::D2_W-1:0] sqx_s3, sqy_s3, d2;
	logic signed [18:0] cxe, cye, lx, ly, nxp, nyp, dxf, dyf;

	always_comb begin
		cxe = {{2{cx_q[16]}}, cx_q};
		cye = {{2{cy_q[16]}}, cy_q};
		lx  = $signed({3'b0, px_s1, 8'b0});
		ly  = $signed({3'b0, py_s1, 8'b0});
		nxp = (cxe < lx) ? lx : ((cxe > lx + 19'sd256) ? lx + 19'sd256 : cxe);
		nyp = (cye < ly) ? ly : ((cye > ly + 19'sd256) ? ly + 19'sd256 : cye);
		dxf = cxe - nxp;
		dyf = cye - nyp;
		d2  = sqx_s3 + sqy_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan;
			v_s2 <= v_s1 & rd_wall;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_s1  <= px_q;
		py_s1  <= py_q;
		dx_s2  <= dxf[cgw_pkg::DX_W-1:0];
		dy_s2  <= dyf[cgw_pkg::DX_W-1:0];
		dx_s3  <= dx_s2;
		dy_s3  <= dy_s2;
		sqx_s3 <= cgw_pkg::D2_W'(dx_s2) * cgw_pkg::D2_W'(dx_s2);
		sqy_s3 <= cgw_pkg::D2_W'(dy_s2) * cgw_pkg::D2_W'(dy_s2);
	end

	// ---------------- best cell ----------------
	logic found_q;
	logic [cgw_pkg::D2_W-1:0] best_d2_q;
	logic signed [cgw_pkg::DX_W-1:0] best_dx_q, best_dy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
		end else if (v_s3 && d2 < r2_q && (!found_q || d2 < best_d2_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && d2 < r2_q && (!found_q || d2 < best_d2_q)) begin
			best_d2_q <= d2;
			best_dx_q <= dx_s3;
			best_dy_q <= dy_s3;
		end
	end

	// ---------------- square root, one result bit a cycle ----------------
	logic [4:0] sq_cnt_q;
	logic [cgw_pkg::SQ_IN_W-1:0]   sv_q;
	logic [cgw_pkg::SQ_REM_W-1:0]  sq_rem_q;
	logic [cgw_pkg::ROOT_W-1:0]    root_q, root_fin;
	logic [cgw_pkg::SQ_REM_W+1:0]  sq_rm, sq_trial;

	assign sq_rm    = {sq_rem_q, sv_q[cgw_pkg::SQ_IN_W-1 -: 2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	// Root including the bit decided this cycle
	assign root_fin = cmd.sq_step ? {root_q[cgw_pkg::ROOT_W-2:0], sq_rm >= sq_trial} : root_q;

	always_ff @(posedge clk) begin
		if (cmd.sq_init) begin
			sq_cnt_q <= 5'(cgw_pkg::ROOT_W - 1);
			sv_q     <= {best_d2_q, 28'b0};
			sq_rem_q <= '0;
			root_q   <= '0;
		end else if (cmd.sq_step) begin
			sq_cnt_q <= sq_cnt_q - 1'b1;
			sv_q     <= {sv_q[cgw_pkg::SQ_IN_W-3:0], 2'b00};
			if (sq_rm >= sq_trial) begin
				sq_rem_q <= cgw_pkg::SQ_REM_W'(sq_rm - sq_trial);
				root_q   <= {root_q[cgw_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				sq_rem_q <= sq_rm[cgw_pkg::SQ_REM_W-1:0];
				root_q   <= {root_q[cgw_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	// ---------------- divide, one quotient bit a cycle ----------------
	logic [4:0] dv_cnt_q;
	logic       dv_sel_q, dv_neg_q;
	logic [cgw_pkg::ROOT_W-1:0] dv_rem_q;
	logic [cgw_pkg::Q_W-1:0]    nl_q, q_q, q_next;
	logic [cgw_pkg::ROOT_W:0]   dv_t;
	logic signed [cgw_pkg::DX_W-1:0] dv_src, dv_abs;
	logic [cgw_pkg::NUM_W-1:0]  num;
	logic [cgw_pkg::N_W-1:0]    mag, comp;
	logic signed [cgw_pkg::N_W-1:0] nx_q, ny_q;
	logic dv_ge;

	always_comb begin
		dv_src = cmd.dv_sel ? best_dy_q : best_dx_q;
		dv_abs = dv_src[cgw_pkg::DX_W-1] ? -dv_src : dv_src;
		num    = {1'b0, dv_abs[cgw_pkg::DX_W-2:0], 28'b0}
			+ cgw_pkg::NUM_W'(root_fin[cgw_pkg::ROOT_W-1:1]);
		dv_t   = {dv_rem_q, nl_q[cgw_pkg::Q_W-1]};
		dv_ge  = dv_t >= {1'b0, root_q};
		q_next = {q_q[cgw_pkg::Q_W-2:0], dv_ge};
		mag    = (q_next > cgw_pkg::Q_W'(cgw_pkg::NORM_ONE)) ? cgw_pkg::NORM_ONE
			: q_next[cgw_pkg::N_W-1:0];
		comp   = dv_neg_q ? -mag : mag;
	end

	always_ff @(posedge clk) begin
		if (cmd.dv_init) begin
			dv_cnt_q <= 5'(cgw_pkg::Q_W - 1);
			dv_sel_q <= cmd.dv_sel;
			dv_neg_q <= dv_src[cgw_pkg::DX_W-1];
			dv_rem_q <= cgw_pkg::ROOT_W'(num[cgw_pkg::NUM_W-1:cgw_pkg::Q_W]);
			nl_q     <= num[cgw_pkg::Q_W-1:0];
			q_q      <= '0;
		end else if (cmd.dv_step) begin
			dv_cnt_q <= dv_cnt_q - 1'b1;
			nl_q     <= {nl_q[cgw_pkg::Q_W-2:0], 1'b0};
			q_q      <= q_next;
			dv_rem_q <= dv_ge ? cgw_pkg::ROOT_W'(dv_t - {1'b0, root_q})
				: dv_t[cgw_pkg::ROOT_W-1:0];
		end
		// Store the finished component, even when the next divide starts now
		if (cmd.dv_step && dv_cnt_q == '0) begin
			if (dv_sel_q) ny_q <= comp;
			else          nx_q <= comp;
		end
	end

	// ---------------- status and result ----------------
	logic on_cell;
	assign on_cell = (best_d2_q == '0);

	always_comb begin
		sts.clr_last  = &clr_q;
		sts.empty     = empty_q;
		sts.scan_last = (px_q == x1_q) && (py_q == y1_q);
		sts.pipe_busy = v_s1 | v_s2 | v_s3;
		sts.sq_last   = (sq_cnt_q == '0);
		sts.dv_last   = (dv_cnt_q == '0);
		sts.out_free  = 1'b0;

		res.hit         = found_q;
		res.penetration = found_q ? r_q - root_q[cgw_pkg::ROOT_W-1 -: cgw_pkg::R_W] : '0;
		res.normal_x    = (!found_q || on_cell) ? '0 : nx_q;
		res.normal_y    = !found_q ? '0 : (on_cell ? -cgw_pkg::NORM_ONE : ny_q);
	end

endmodule

[rtl/circle_grid_wall_collision.sv]
// ----------------------------------------------------------------------------
// circle_grid_wall_collision
// Circle against tile grid wall collision: a one-bit wall map written cell by
// cell, and queries that report hit, penetration depth and push-out normal.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tuser: operation; tdata: cell_index, cell_is_wall,
//                       center_x, center_y, circle_radius
//  m_axis    out        tdata: hit, penetration, normal_x, normal_y
//  cfg       in         cfg_index 0 grid_width, 1 grid_height
//
// After reset the wall map is cleared, one cell a cycle, with s_axis_tready
// low; configuration writes are taken throughout. A query runs the cell scan,
// which reads one map cell a cycle (up to 18 x 18), then a bit-serial square
// root and two bit-serial divides. One item is worked on at a time. The
// result waits in an output register; a new item is taken while it waits,
// and a following query holds at its end until the register is free.
// ----------------------------------------------------------------------------
module circle_grid_wall_collision (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // cell_index[15:0], cell_is_wall[16],
	                                   // center_x[33:17], center_y[50:34],
	                                   // circle_radius[62:51], zero[63]
	input  logic        s_axis_tuser,  // operation[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // hit[0], penetration[12:1],
	                                   // normal_x[28:13], normal_y[44:29], zero[47:45]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	cgw_pkg::cmd_t    cmd;
	cgw_pkg::status_t sts, dp_sts;
	cgw_pkg::item_t   item;
	cgw_pkg::result_t res;

	logic [cgw_pkg::DIM_W-1:0] width_q, height_q;
	logic        out_valid_q;
	logic [47:0] out_data_q;

	// Hold the grid size; writes must arrive only while idle, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == cgw_pkg::REG_WIDTH)  width_q  <= cfg_data;
			if (cfg_index == cgw_pkg::REG_HEIGHT) height_q <= cfg_data;
		end
	end

	// Unpack the input payload.
	assign item.cell_index    = s_axis_tdata[15:0];
	assign item.cell_is_wall  = s_axis_tdata[16];
	assign item.center_x      = $signed(s_axis_tdata[33:17]);
	assign item.center_y      = $signed(s_axis_tdata[50:34]);
	assign item.circle_radius = s_axis_tdata[62:51];

	// Output slot is free when empty or being taken this cycle.
	always_comb begin
		sts          = dp_sts;
		sts.out_free = !out_valid_q || m_axis_tready;
	end

	cgw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.sts      (sts),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	cgw_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.item        (item),
		.grid_width  (width_q),
		.grid_height (height_q),
		.sts         (dp_sts),
		.res         (res)
	);

	// Result register: load on finish, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_data_q <= {3'b000, res.normal_y, res.normal_x, res.penetration, res.hit};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A finished result never overwrites one still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> (!out_valid_q || m_axis_tready))
		else $error("result register overwritten");

	// A reported hit always has a nonzero depth.
	a_hit_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_out && res.hit) |-> (res.penetration != '0))
		else $error("hit with zero penetration");

	// A miss reports all fields zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_out && !res.hit) |-> (res.penetration == '0 && res.normal_x == '0
			&& res.normal_y == '0))
		else $error("miss with nonzero fields");

	// The scan pipeline is empty by the time a result is loaded.
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> !dp_sts.pipe_busy)
		else $error("result loaded while cells in flight");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Tests the circle against grid wall collision block. Wall map writes and
// queries go in on the item stream. A model kept in the bench mirrors the
// wall map and the grid size, and predicts every query result. The checker
// compares each result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLEAR_CYCLES = 65536;
	localparam int SETTLE       = 400;      // longest query, with margin
	localparam int LIMIT        = 4000000;  // clear pass + 1500 slow items, several times over

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [8:0]  cfg_data;

	circle_grid_wall_collision u_top (.*);

	// Bench copy of the block's state
	bit      wall_cells [0:cgw_pkg::MAP_CELLS-1];
	int      grid_w;
	int      grid_h;

	cgw_pkg::result_t contact_queue [$];
	int      errors;
	int      cycles;
	int      queries;
	int      hits;
	int      map_writes;
	bit      calm;       // no idling on either side when set

	always #1 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, contact_queue.size());
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Round half away from zero, saturate to unit length
	function automatic logic [cgw_pkg::N_W-1:0] unit_comp(longint num, longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = longint'(num < 0 ? -num : num) << 28;
		q   = (mag + den / 2) / den;
		if (q > 16384)
			q = 16384;
		return num < 0 ? cgw_pkg::N_W'(-longint'(q)) : cgw_pkg::N_W'(q);
	endfunction

	// Predict the contact of one query against the current map and grid
	function automatic cgw_pkg::result_t predict_contact(
		logic signed [cgw_pkg::C_W-1:0] cx_in,
		logic signed [cgw_pkg::C_W-1:0] cy_in, logic [cgw_pkg::R_W-1:0] r_in);
		cgw_pkg::result_t res;
		longint          cx, cy, r, w, h, x0, x1, y0, y1, r2;
		longint          lx, ly, nx, ny, dx, dy, d2, best_d2, best_dx, best_dy, root_d;
		longint unsigned den;
		bit              found;
		cx = cx_in;
		cy = cy_in;
		r  = (r_in > cgw_pkg::R_MAX) ? longint'(cgw_pkg::R_MAX) : longint'(r_in);
		w  = grid_w > cgw_pkg::MAX_WIDTH ? cgw_pkg::MAX_WIDTH : grid_w;
		h  = grid_h > cgw_pkg::MAX_HEIGHT ? cgw_pkg::MAX_HEIGHT : grid_h;
		found   = 0;
		best_d2 = 0;
		best_dx = 0;
		best_dy = 0;
		res     = '0;
		if (w > 0 && h > 0) begin
			x0 = (cx - r) >>> 8;
			y0 = (cy - r) >>> 8;
			x1 = -((-(cx + r)) >>> 8);
			y1 = -((-(cy + r)) >>> 8);
			r2 = r * r;
			if (x0 < 0) x0 = 0;
			if (y0 < 0) y0 = 0;
			if (x1 > w - 1) x1 = w - 1;
			if (y1 > h - 1) y1 = h - 1;
			for (longint py = y0; py <= y1; py++) begin
				for (longint px = x0; px <= x1; px++) begin
					if (py * w + px >= cgw_pkg::MAP_CELLS || !wall_cells[py * w + px])
						continue;
					lx = px * 256;
					ly = py * 256;
					nx = cx < lx ? lx : (cx > lx + 256 ? lx + 256 : cx);
					ny = cy < ly ? ly : (cy > ly + 256 ? ly + 256 : cy);
					dx = cx - nx;
					dy = cy - ny;
					d2 = dx * dx + dy * dy;
					// strict compare keeps the first cell in raster order on ties
					if (d2 < r2 && (!found || d2 < best_d2)) begin
						found   = 1;
						best_d2 = d2;
						best_dx = dx;
						best_dy = dy;
					end
				end
			end
		end
		if (!found)
			return res;
		root_d          = longint'(int_sqrt(best_d2));
		res.hit         = 1'b1;
		res.penetration = cgw_pkg::R_W'(r - root_d);
		if (best_d2 == 0) begin
			// center inside the cell: push straight up
			res.normal_x = '0;
			res.normal_y = cgw_pkg::N_W'(-16384);
		end else begin
			den          = int_sqrt(longint'(best_d2) << 28);
			res.normal_x = unit_comp(best_dx, den);
			res.normal_y = unit_comp(best_dy, den);
		end
		return res;
	endfunction

	// Check each result item against the oldest prediction
	always @(posedge clk) begin
		cgw_pkg::result_t want;
		cgw_pkg::result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hit         = m_axis_tdata[0];
			got.penetration = m_axis_tdata[12:1];
			got.normal_x    = m_axis_tdata[28:13];
			got.normal_y    = m_axis_tdata[44:29];
			if (contact_queue.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, got);
				errors++;
			end else begin
				want = contact_queue.pop_front();
				if (got.hit !== want.hit) begin
					$display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
					errors++;
				end
				if (got.penetration !== want.penetration) begin
					$display("%0t: penetration expected %0d actual %0d", $time,
						want.penetration, got.penetration);
					errors++;
				end
				if (got.normal_x !== want.normal_x) begin
					$display("%0t: normal_x expected %0d actual %0d", $time,
						$signed(want.normal_x), $signed(got.normal_x));
					errors++;
				end
				if (got.normal_y !== want.normal_y) begin
					$display("%0t: normal_y expected %0d actual %0d", $time,
						$signed(want.normal_y), $signed(got.normal_y));
					errors++;
				end
			end
		end
	end

	// Result side: stall in random bursts unless calm
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Send one item, maybe after a random gap; mirror it in the bench model
	task automatic send_item(logic op, logic [15:0] idx, logic wall,
		logic signed [cgw_pkg::C_W-1:0] cx, logic signed [cgw_pkg::C_W-1:0] cy,
		logic [cgw_pkg::R_W-1:0] r);
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {1'b0, r, cy, cx, wall, idx};
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		if (op == cgw_pkg::OP_QUERY) begin
			cgw_pkg::result_t p;
			p = predict_contact(cx, cy, r);
			contact_queue.push_back(p);
			queries++;
			hits += p.hit;
		end else begin
			wall_cells[idx] = wall;
			map_writes++;
		end
	endtask

	task automatic write_wall(int px, int py, logic wall);
		int w;
		w = grid_w > cgw_pkg::MAX_WIDTH ? cgw_pkg::MAX_WIDTH : grid_w;
		send_item(cgw_pkg::OP_WRITE, 16'(py * w + px), wall, '0, '0, '0);
	endtask

	task automatic query(int cx, int cy, int r);
		send_item(cgw_pkg::OP_QUERY, 16'($urandom), 1'($urandom), cgw_pkg::C_W'(cx),
			cgw_pkg::C_W'(cy), cgw_pkg::R_W'(r));
	endtask

	// Hold until every result is in, then let a write-only tail settle
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (contact_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_grid(int w, int h);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= cgw_pkg::REG_WIDTH;
		cfg_data  <= 9'(w);
		@(negedge clk);
		cfg_index <= cgw_pkg::REG_HEIGHT;
		cfg_data  <= 9'(h);
		@(negedge clk);
		cfg_we    <= 1'b0;
		grid_w = w;
		grid_h = h;
	endtask

	// Grid still zero-sized, then one dimension zero: no hit anywhere
	task automatic test_disabled_grid();
		write_wall(0, 0, 1'b1);
		query(128, 128, 512);
		set_grid(4, 0);
		query(128, 128, 512);
	endtask

	// Extremes of the fields and each special case, on a full-size grid
	task automatic test_directed();
		set_grid(256, 256);
		write_wall(3, 5, 1'b1);
		write_wall(255, 255, 1'b1);
		write_wall(0, 0, 1'b1);
		query(3 * 256 + 128, 5 * 256 + 128, 256);      // center on the cell
		query(2 * 256 + 128, 5 * 256 + 128, 256);      // left face
		query(4 * 256 + 200, 6 * 256 + 100, 256);      // corner, diagonal normal
		query(3 * 256 + 128, 4 * 256, 0);              // zero radius
		query(3 * 256 + 128, 3 * 256 + 128, 4095);     // radius saturates
		query(-65536, -65536, 4095);                   // box off the grid
		query(65535, 65535, 4095);                     // far corner, clamped box
		query(65535, 255 * 256 + 128, 60);             // at the right edge
		query(-20, 128, 21);                           // just left of the grid
		query(-20, 128, 20);                           // touching, no overlap
		write_wall(3, 5, 1'b0);                        // free it again
		query(3 * 256 + 128, 5 * 256 + 128, 256);
		send_item(cgw_pkg::OP_WRITE, 16'hFFFF, 1'b0, cgw_pkg::C_W'(-1), cgw_pkg::C_W'(-1),
			12'hFFF);
		query(255 * 256 + 128, 255 * 256 + 128, 2048);
		write_wall(4, 4, 1'b1);
		write_wall(5, 4, 1'b1);
		query(4 * 256 + 256, 3 * 256 + 128, 300);      // tie: first in raster order wins
	endtask

	// Well-formed traffic: walls near a spot, queries around it; some noise
	task automatic test_random_grid(int w, int h, int n_items);
		int ew, eh, ax, ay, k;
		set_grid(w, h);
		ew = w > cgw_pkg::MAX_WIDTH ? cgw_pkg::MAX_WIDTH : w;
		eh = h > cgw_pkg::MAX_HEIGHT ? cgw_pkg::MAX_HEIGHT : h;
		k = 0;
		while (k < n_items) begin
			ax = $urandom_range(0, ew - 1);
			ay = $urandom_range(0, eh - 1);
			repeat ($urandom_range(1, 8)) begin
				write_wall((ax + $urandom_range(0, 6)) % ew, (ay + $urandom_range(0, 6)) % eh,
					1'($urandom_range(0, 3) != 0));
				k++;
			end
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 9) == 0)
					send_item(1'($urandom), 16'($urandom), 1'($urandom),
						cgw_pkg::C_W'($urandom), cgw_pkg::C_W'($urandom),
						cgw_pkg::R_W'($urandom));
				else
					query(ax * 256 + $urandom_range(0, 2300) - 256,
						ay * 256 + $urandom_range(0, 2300) - 256,
						$urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
							: $urandom_range(1, 900));
				k++;
			end
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		calm          = 1'b0;
		errors        = 0;
		cycles        = 0;
		queries       = 0;
		hits          = 0;
		map_writes    = 0;
		grid_w        = 0;
		grid_h        = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_disabled_grid();
		test_directed();
		test_random_grid(16, 12, 300);
		test_random_grid(1, 1, 60);
		test_random_grid(256, 256, 300);
		test_random_grid(511, 300, 250);   // both act as the maximum
		test_random_grid(7, 40, 250);
		calm = 1'b1;
		test_random_grid(33, 9, 300);
		drain();

		$display("Covered %0d queries (%0d hits) and %0d map writes over several grid sizes.",
			queries, hits, map_writes);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[circle_grid_wall_collision.f]
rtl/cgw_pkg.sv
rtl/cgw_ram.sv
rtl/cgw_ctrl.sv
rtl/cgw_dp.sv
rtl/circle_grid_wall_collision.sv
test/testbench.sv
